### rtl/core/lna_pkg.sv
package lna_pkg;

    localparam int IDX_W      = 10;
    localparam int STEP_W     = 32;
    localparam int POT_W      = 32;
    localparam int REFR_W     = 16;
    localparam int DECAY_W    = 16;
    localparam int FRAC_W     = 16;
    localparam int REM_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_REFRACTORY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd4;

    localparam logic [REFR_W-1:0]  REFR_RST  = 16'd0;
    localparam logic [DECAY_W-1:0] DECAY_RST = 16'hFFFF;
    localparam logic [POT_W-1:0]   THR_RST   = 32'h0001_0000;
    localparam logic [POT_W-1:0]   LEVEL_RST = 32'h0000_0000;
    localparam logic               MODE_RST  = 1'b0;

    localparam logic [POT_W-1:0] POT_MAX = 32'h7FFF_FFFF;
    localparam logic [POT_W-1:0] POT_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [IDX_W-1:0]        neuron_index;
        logic [STEP_W-1:0]       step_number;
        logic signed [POT_W-1:0] synaptic_input;
    } item_t;

    typedef struct packed {
        logic [IDX_W-1:0]        neuron_out;
        logic                    spiked;
        logic                    was_refractory;
        logic signed [POT_W-1:0] new_potential;
        logic                    saturated;
        logic                    mode_fault;
    } result_t;

    typedef struct packed {
        logic [REFR_W-1:0]       refractory_steps;
        logic [DECAY_W-1:0]      decay_factor;
        logic signed [POT_W-1:0] threshold;
        logic signed [POT_W-1:0] reset_level;
        logic                    reset_mode;
    } cfg_t;

    typedef struct packed {
        logic signed [POT_W-1:0] potential;
        logic [STEP_W-1:0]       last_step;
        logic                    has_spiked;
    } nstate_t;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
    } tag_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             wr_en;
        logic             use_rem;
        nstate_t          entry;
        logic             spiked;
        logic             refr;
        logic             sat;
        logic             fault;
    } side_t;

endpackage

### rtl/core/lna_cfg.sv
module lna_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_valid,
    input  logic [lna_pkg::CFG_IDX_W-1:0]     wr_index,
    input  logic [lna_pkg::CFG_DATA_W-1:0]    wr_data,
    output lna_pkg::cfg_t                     cfg
);
    import lna_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_valid)
        begin
            unique case (wr_index)
                CFG_REFRACTORY: cfg_next.refractory_steps = wr_data[REFR_W-1:0];
                CFG_DECAY:      cfg_next.decay_factor     = wr_data[DECAY_W-1:0];
                CFG_THRESHOLD:  cfg_next.threshold        = $signed(wr_data[POT_W-1:0]);
                CFG_LEVEL:      cfg_next.reset_level      = $signed(wr_data[POT_W-1:0]);
                CFG_MODE:       cfg_next.reset_mode       = wr_data[0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.refractory_steps <= REFR_RST;
            cfg_reg.decay_factor     <= DECAY_RST;
            cfg_reg.threshold        <= $signed(THR_RST);
            cfg_reg.reset_level      <= $signed(LEVEL_RST);
            cfg_reg.reset_mode       <= MODE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/core/lna_state_mem.sv
module lna_state_mem #(
    parameter int unsigned NEURONS = 1024,
    localparam int unsigned ADDR_W = (NEURONS > 1) ? $clog2(NEURONS) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output lna_pkg::nstate_t    rd_data,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  lna_pkg::nstate_t    wr_data,
    output logic                clearing
);
    import lna_pkg::*;

    nstate_t            mem [NEURONS];
    nstate_t            rd_data_reg;
    logic               clearing_reg;
    logic [ADDR_W-1:0]  clr_addr_reg;

    // sweep zeros through every entry after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == ADDR_W'(NEURONS - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clearing_reg;

endmodule

### rtl/core/lna_rem_pipe.sv
module lna_rem_pipe (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   advance,
    input  logic                                   in_valid,
    input  lna_pkg::side_t                         in_side,
    input  logic [lna_pkg::REM_W-1:0]              in_num,
    input  logic [lna_pkg::REM_W-1:0]              in_den,
    output logic                                   out_valid,
    output lna_pkg::side_t                         out_side,
    output logic [lna_pkg::REM_W-1:0]              out_rem,
    output lna_pkg::tag_t [lna_pkg::REM_W-1:0]     tags
);
    import lna_pkg::*;

    logic [REM_W-1:0] valid_reg;
    logic [REM_W-1:0] valid_next;
    side_t            side_reg  [REM_W];
    side_t            side_next [REM_W];
    logic [REM_W-1:0] num_reg   [REM_W];
    logic [REM_W-1:0] num_next  [REM_W];
    logic [REM_W-1:0] den_reg   [REM_W];
    logic [REM_W-1:0] den_next  [REM_W];
    logic [REM_W-1:0] rem_reg   [REM_W];
    logic [REM_W-1:0] rem_next  [REM_W];
    logic [REM_W-1:0] prev_num  [REM_W];
    logic [REM_W-1:0] prev_rem  [REM_W];
    logic [REM_W:0]   shifted   [REM_W];
    logic [REM_W+1:0] trial     [REM_W];

    assign valid_next = {valid_reg[REM_W-2:0], in_valid};

    // one restoring remainder step per stage, dividend bits from the top
    always_comb
    begin
        for (int k = 0; k < REM_W; k++)
        begin
            if (k == 0)
            begin
                prev_num[k]  = in_num;
                prev_rem[k]  = '0;
                den_next[k]  = in_den;
                side_next[k] = in_side;
            end
            else
            begin
                prev_num[k]  = num_reg[k-1];
                prev_rem[k]  = rem_reg[k-1];
                den_next[k]  = den_reg[k-1];
                side_next[k] = side_reg[k-1];
            end
            shifted[k]  = {prev_rem[k], prev_num[k][REM_W-1]};
            trial[k]    = {1'b0, shifted[k]} - {2'b00, den_next[k]};
            rem_next[k] = trial[k][REM_W+1] ? shifted[k][REM_W-1:0] : trial[k][REM_W-1:0];
            num_next[k] = {prev_num[k][REM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            side_reg <= side_next;
            num_reg  <= num_next;
            den_reg  <= den_next;
            rem_reg  <= rem_next;
        end
    end

    always_comb
    begin
        for (int k = 0; k < REM_W; k++)
        begin
            tags[k].valid = valid_reg[k];
            tags[k].idx   = side_reg[k].idx;
        end
    end

    assign out_valid = valid_reg[REM_W-1];
    assign out_side  = side_reg[REM_W-1];
    assign out_rem   = rem_reg[REM_W-1];

endmodule

### rtl/core/lif_neuron_array_update.sv
// Leaky integrate-and-fire update engine: each item updates one neuron held in
// a single-port-read, single-port-write state memory and returns one result.
// Items enter at one per cycle unless the result side stalls, the state memory
// is clearing or a same-neuron hold-off applies; each item passes stages a, b
// and c, the 32-stage remainder pipeline that carries out the subtractive reset,
// and the result register. An item whose neuron is still in flight is held off
// until the earlier update has been written back. After reset a clearing pass
// zeroes the state memory, during which no item is taken; configuration writes
// are taken at any time but must only change while the engine is empty.
module lif_neuron_array_update #(
    parameter int unsigned NEURONS = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  lna_pkg::item_t                    item,
    output logic                              result_valid,
    input  logic                              result_ready,
    output lna_pkg::result_t                  result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lna_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lna_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import lna_pkg::*;

    localparam int unsigned ADDR_W = (NEURONS > 1) ? $clog2(NEURONS) : 1;
    localparam int unsigned MUL_W  = POT_W + DECAY_W + 1;

    cfg_t                    cfg;
    logic                    clearing;
    logic                    advance;
    logic                    hazard;
    logic                    accept;
    logic [31:0]             in_idx_wide;
    logic                    in_range;
    logic [ADDR_W-1:0]       rd_addr;
    nstate_t                 rd_data;
    logic                    wr_en;
    logic [31:0]             wr_idx_wide;
    logic [ADDR_W-1:0]       wr_addr;
    nstate_t                 wr_data;

    logic                    a_valid_reg;
    item_t                   a_item_reg;
    logic                    a_inrange_reg;

    logic                    b_valid_reg;
    item_t                   b_item_reg;
    logic                    b_inrange_reg;
    logic                    b_refr_reg;
    logic                    b_refr_next;
    nstate_t                 b_entry_reg;
    logic signed [MUL_W-1:0] b_prod_reg;
    logic signed [MUL_W-1:0] b_prod_next;
    logic [STEP_W-1:0]       step_diff;

    logic                    c_valid_reg;
    item_t                   c_item_reg;
    logic                    c_inrange_reg;
    logic                    c_refr_reg;
    nstate_t                 c_entry_reg;
    logic signed [POT_W-1:0] c_pot_reg;
    logic signed [POT_W-1:0] c_pot_next;
    logic                    c_sat_reg;
    logic                    c_sat_next;
    logic [POT_W:0]          prod_sh;
    logic signed [POT_W+1:0] sum;
    logic                    sum_clip;
    logic [POT_W-1:0]        sum_sat;

    logic                    spike;
    logic                    level_ok;
    logic [REM_W-1:0]        rem_num;
    logic [REM_W-1:0]        rem_den;
    side_t                   rem_side;

    logic                    w_valid;
    side_t                   w_side;
    logic [REM_W-1:0]        w_rem;
    tag_t [REM_W-1:0]        tags;
    logic [POT_W-1:0]        wb_sub;
    nstate_t                 wb_entry;

    result_t                 result_reg;
    logic                    result_valid_reg;
    logic                    result_valid_next;

    lna_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign cfg_ready = 1'b1;

    // handshake and same-neuron interlock
    assign advance = !result_valid_reg || result_ready || !w_valid;

    always_comb
    begin
        hazard = (a_valid_reg && (a_item_reg.neuron_index == item.neuron_index))
              || (b_valid_reg && (b_item_reg.neuron_index == item.neuron_index))
              || (c_valid_reg && (c_item_reg.neuron_index == item.neuron_index));
        for (int k = 0; k < REM_W; k++)
        begin
            if (tags[k].valid && (tags[k].idx == item.neuron_index))
            begin
                hazard = 1'b1;
            end
        end
    end

    assign item_ready  = advance && !clearing && !hazard;
    assign accept      = item_valid && item_ready;
    assign in_idx_wide = 32'(item.neuron_index);
    assign in_range    = in_idx_wide < 32'(NEURONS);
    assign rd_addr     = in_idx_wide[ADDR_W-1:0];

    lna_state_mem #(
        .NEURONS (NEURONS)
    ) u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .clearing (clearing)
    );

    // refractory test and decay product
    assign step_diff   = a_item_reg.step_number - rd_data.last_step;
    assign b_refr_next = a_inrange_reg && rd_data.has_spiked
                      && (step_diff <= STEP_W'(cfg.refractory_steps));
    assign b_prod_next = rd_data.potential * $signed({1'b0, cfg.decay_factor});

    // floor shift, integrate, saturate
    assign prod_sh  = b_prod_reg[MUL_W-1:FRAC_W];
    assign sum      = $signed({prod_sh[POT_W], prod_sh})
                    + $signed({{2{b_item_reg.synaptic_input[POT_W-1]}},
                               b_item_reg.synaptic_input});
    assign sum_clip = !((sum[POT_W+1:POT_W-1] == 3'b000) || (sum[POT_W+1:POT_W-1] == 3'b111));
    assign sum_sat  = sum_clip ? (sum[POT_W+1] ? POT_MIN : POT_MAX) : sum[POT_W-1:0];

    always_comb
    begin
        if (!b_inrange_reg)
        begin
            c_pot_next = '0;
        end
        else if (b_refr_reg)
        begin
            c_pot_next = b_entry_reg.potential;
        end
        else
        begin
            c_pot_next = $signed(sum_sat);
        end
    end

    assign c_sat_next = b_inrange_reg && !b_refr_reg && sum_clip;

    // spike decision and remainder operands
    assign spike    = c_inrange_reg && !c_refr_reg && (c_pot_reg > cfg.threshold);
    assign level_ok = cfg.reset_level < cfg.threshold;
    assign rem_num  = c_pot_reg - cfg.threshold - POT_W'(1);
    assign rem_den  = cfg.threshold - cfg.reset_level;

    always_comb
    begin
        rem_side.idx              = c_item_reg.neuron_index;
        rem_side.wr_en            = c_inrange_reg && !c_refr_reg;
        rem_side.use_rem          = spike && cfg.reset_mode && level_ok;
        rem_side.entry.potential  = spike ? cfg.reset_level : c_pot_reg;
        rem_side.entry.last_step  = spike ? c_item_reg.step_number : c_entry_reg.last_step;
        rem_side.entry.has_spiked = spike || c_entry_reg.has_spiked;
        rem_side.spiked           = spike;
        rem_side.refr             = c_refr_reg;
        rem_side.sat              = c_sat_reg;
        rem_side.fault            = spike && cfg.reset_mode && !level_ok;
    end

    lna_rem_pipe u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (c_valid_reg),
        .in_side   (rem_side),
        .in_num    (rem_num),
        .in_den    (rem_den),
        .out_valid (w_valid),
        .out_side  (w_side),
        .out_rem   (w_rem),
        .tags      (tags)
    );

    // write back: subtractive reset lands at reset_level + 1 + remainder
    assign wb_sub = cfg.reset_level + w_rem + POT_W'(1);

    always_comb
    begin
        wb_entry = w_side.entry;
        if (w_side.use_rem)
        begin
            wb_entry.potential = $signed(wb_sub);
        end
    end

    assign wr_en       = advance && w_valid && w_side.wr_en;
    assign wr_idx_wide = 32'(w_side.idx);
    assign wr_addr     = wr_idx_wide[ADDR_W-1:0];
    assign wr_data     = wb_entry;

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (advance && w_valid)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg      <= 1'b0;
            b_valid_reg      <= 1'b0;
            c_valid_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            if (advance)
            begin
                a_valid_reg <= accept;
                b_valid_reg <= a_valid_reg;
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_item_reg    <= item;
            a_inrange_reg <= in_range;
            b_item_reg    <= a_item_reg;
            b_inrange_reg <= a_inrange_reg;
            b_refr_reg    <= b_refr_next;
            b_entry_reg   <= rd_data;
            b_prod_reg    <= b_prod_next;
            c_item_reg    <= b_item_reg;
            c_inrange_reg <= b_inrange_reg;
            c_refr_reg    <= b_refr_reg;
            c_entry_reg   <= b_entry_reg;
            c_pot_reg     <= c_pot_next;
            c_sat_reg     <= c_sat_next;
            if (w_valid)
            begin
                result_reg.neuron_out     <= w_side.idx;
                result_reg.spiked         <= w_side.spiked;
                result_reg.was_refractory <= w_side.refr;
                result_reg.new_potential  <= wb_entry.potential;
                result_reg.saturated      <= w_side.sat;
                result_reg.mode_fault     <= w_side.fault;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> (!wr_en && !item_ready))
        else $error("state memory touched during clearing pass");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && accept && in_range) |-> (wr_addr != rd_addr))
        else $error("item read a neuron that is being written back");

    a_sub_range: assert property (@(posedge clk) disable iff (!rst_n)
        (w_valid && w_side.use_rem) |->
            (($signed(wb_sub) <= cfg.threshold) && ($signed(wb_sub) > cfg.reset_level)))
        else $error("subtractive reset left potential outside (reset_level, threshold]");

    a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && w_valid) |=> result_valid)
        else $error("finished item did not reach the result register");

endmodule

### verif/lif_neuron_array_update_tb.sv
module lif_neuron_array_update_tb;
    import lna_pkg::*;

    localparam int NEURONS = 1024;
    localparam int PHASES = 7;
    localparam int FIXED_PHASES = 5;
    localparam int ITEMS_PER_PHASE = 56;
    localparam int POOL = 8;
    localparam int HOLD_AT = 120;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_PRINTED = 40;
    localparam longint POT_HI = 64'sd2147483647;
    localparam longint POT_LO = -64'sd2147483648;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef enum logic [1:0] {ROW_PREDICT, ROW_KNOWN, ROW_WRITE} row_e;

    typedef struct packed {
        row_e                  kind;
        logic [CFG_IDX_W-1:0]  sel;
        logic [CFG_DATA_W-1:0] val;
        item_t                 stim;
        result_t               want;
    } row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  item_valid = 1'b0;
    logic                  item_ready;
    item_t                 item = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    result_t               result;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int cycles = 0;
    int items_sent = 0;
    int results_seen = 0;
    int mismatches = 0;
    int spikes_seen = 0;
    int frozen_seen = 0;
    int clipped_seen = 0;
    int faults_seen = 0;
    bit held_off = 1'b0;

    logic signed [POT_W-1:0] potential_mem [NEURONS] = '{default: '0};
    logic [STEP_W-1:0]       spike_step_mem [NEURONS] = '{default: '0};
    bit                      fired_mem [NEURONS] = '{default: 1'b0};
    cfg_t                    live_cfg = '{REFR_RST, DECAY_RST, THR_RST, LEVEL_RST, MODE_RST};
    result_t                 expected_results [$];

    row_t directed_rows [26] = '{
        '{ROW_KNOWN, '0, '0, '{10'd0, 32'd0, 32'h0000_0000},
            '{10'd0, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 1'b0}},
        '{ROW_KNOWN, '0, '0, '{10'd1023, 32'hFFFF_FFFF, 32'h7FFF_FFFF},
            '{10'd1023, 1'b1, 1'b0, 32'h0000_0000, 1'b0, 1'b0}},
        '{ROW_KNOWN, '0, '0, '{10'd1023, 32'd0, 32'h0000_0000},
            '{10'd1023, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 1'b0}},
        '{ROW_KNOWN, '0, '0, '{10'd2, 32'd5, 32'h0002_0000},
            '{10'd2, 1'b1, 1'b0, 32'h0000_0000, 1'b0, 1'b0}},
        '{ROW_KNOWN, '0, '0, '{10'd2, 32'd5, 32'h0002_0000},
            '{10'd2, 1'b0, 1'b1, 32'h0000_0000, 1'b0, 1'b0}},
        '{ROW_KNOWN, '0, '0, '{10'd4, 32'd6, 32'h8000_0000},
            '{10'd4, 1'b0, 1'b0, 32'h8000_0000, 1'b0, 1'b0}},
        '{ROW_KNOWN, '0, '0, '{10'd4, 32'd7, 32'h8000_0000},
            '{10'd4, 1'b0, 1'b0, 32'h8000_0000, 1'b1, 1'b0}},
        '{ROW_KNOWN, '0, '0, '{10'd5, 32'd8, 32'hFFFF_FFFF},
            '{10'd5, 1'b0, 1'b0, 32'hFFFF_FFFF, 1'b0, 1'b0}},
        '{ROW_KNOWN, '0, '0, '{10'd5, 32'd9, 32'h0000_0000},
            '{10'd5, 1'b0, 1'b0, 32'hFFFF_FFFF, 1'b0, 1'b0}},
        '{ROW_WRITE, CFG_THRESHOLD, 32'h7FFF_FFFF, '0, '0},
        '{ROW_KNOWN, '0, '0, '{10'd7, 32'd10, 32'h7FFF_FFFF},
            '{10'd7, 1'b0, 1'b0, 32'h7FFF_FFFF, 1'b0, 1'b0}},
        '{ROW_KNOWN, '0, '0, '{10'd7, 32'd11, 32'h7FFF_FFFF},
            '{10'd7, 1'b0, 1'b0, 32'h7FFF_FFFF, 1'b1, 1'b0}},
        '{ROW_WRITE, CFG_THRESHOLD, 32'h0001_0000, '0, '0},
        '{ROW_WRITE, CFG_LEVEL, 32'hFFFE_0000, '0, '0},
        '{ROW_WRITE, CFG_MODE, 32'h0000_0001, '0, '0},
        '{ROW_PREDICT, '0, '0, '{10'd8, 32'd12, 32'h000A_8000}, '0},
        '{ROW_PREDICT, '0, '0, '{10'd8, 32'd13, 32'h7FFF_FFFF}, '0},
        '{ROW_WRITE, CFG_LEVEL, 32'h7FFF_FFFF, '0, '0},
        '{ROW_KNOWN, '0, '0, '{10'd9, 32'd13, 32'h0002_0000},
            '{10'd9, 1'b1, 1'b0, 32'h7FFF_FFFF, 1'b0, 1'b1}},
        '{ROW_KNOWN, '0, '0, '{10'd10, 32'd13, 32'h0000_8000},
            '{10'd10, 1'b0, 1'b0, 32'h0000_8000, 1'b0, 1'b0}},
        '{ROW_WRITE, CFG_DECAY, 32'h0000_0000, '0, '0},
        '{ROW_WRITE, CFG_REFRACTORY, 32'h0000_FFFF, '0, '0},
        '{ROW_WRITE, CFG_SPARE_LO, 32'hFFFF_FFFF, '0, '0},
        '{ROW_WRITE, CFG_SPARE_HI, 32'hFFFF_FFFF, '0, '0},
        '{ROW_KNOWN, '0, '0, '{10'd1023, 32'h0000_FFFE, 32'h0000_0005},
            '{10'd1023, 1'b0, 1'b1, 32'h0000_0000, 1'b0, 1'b0}},
        '{ROW_PREDICT, '0, '0, '{10'd1023, 32'h0000_FFFF, 32'h0000_0005}, '0}
    };

    cfg_t fixed_settings [FIXED_PHASES] = '{
        '{16'd2,     16'hF000, 32'h0002_0000, 32'h0000_0000, 1'b1},
        '{16'd0,     16'hFFFF, 32'h4000_0000, 32'h8000_0000, 1'b1},
        '{16'hFFFF,  16'h0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0},
        '{16'd5,     16'h8000, 32'hFFFF_0000, 32'hFFFC_0000, 1'b1},
        '{16'd1,     16'hC000, 32'h0001_0000, 32'h0003_0000, 1'b1}
    };

    lif_neuron_array_update dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
    end

    function automatic result_t lif_update(input item_t it);
        result_t           r;
        logic [IDX_W-1:0]  n;
        logic [STEP_W-1:0] since;
        longint            acc;
        longint            thr;
        longint            lvl;
        longint            span;
        longint            k;
        n = it.neuron_index;
        r = '0;
        r.neuron_out = n;
        since = it.step_number - spike_step_mem[n];
        if (fired_mem[n] && since <= live_cfg.refractory_steps)
        begin
            r.was_refractory = 1'b1;
            r.new_potential = potential_mem[n];
            return r;
        end
        thr = longint'($signed(live_cfg.threshold));
        lvl = longint'($signed(live_cfg.reset_level));
        acc = (longint'(potential_mem[n]) * longint'(live_cfg.decay_factor)) >>> FRAC_W;
        acc = acc + longint'($signed(it.synaptic_input));
        if (acc > POT_HI)
        begin
            acc = POT_HI;
            r.saturated = 1'b1;
        end
        if (acc < POT_LO)
        begin
            acc = POT_LO;
            r.saturated = 1'b1;
        end
        if (acc > thr)
        begin
            r.spiked = 1'b1;
            if (live_cfg.reset_mode && lvl < thr)
            begin
                span = thr - lvl;
                k = (acc - thr + span - 1) / span;
                acc = acc - k * span;
            end
            else
            begin
                r.mode_fault = live_cfg.reset_mode;
                acc = lvl;
            end
            spike_step_mem[n] = it.step_number;
            fired_mem[n] = 1'b1;
        end
        potential_mem[n] = acc[POT_W-1:0];
        r.new_potential = acc[POT_W-1:0];
        return r;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic cfg_t random_setting();
        cfg_t c;
        c.refractory_steps = $urandom_range(0, 6);
        c.decay_factor = $urandom_range(0, 65535);
        c.threshold = $signed($urandom) >>> $urandom_range(8, 20);
        c.reset_level = $signed($urandom) >>> $urandom_range(8, 20);
        c.reset_mode = $urandom_range(0, 1);
        return c;
    endfunction

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("cycle %0d: %s", cycles, what);
    endtask

    task automatic compare_field(input string name, input logic [IDX_W-1:0] n,
                                 input logic [31:0] got, input logic [31:0] want);
        if (got !== want)
            note_mismatch($sformatf("neuron %0d %s: got %h, want %h", n, name, got, want));
    endtask

    task automatic check_result(input result_t got);
        result_t want;
        if (expected_results.size() == 0)
        begin
            note_mismatch($sformatf("result for neuron %0d with nothing pending",
                                    got.neuron_out));
            return;
        end
        want = expected_results.pop_front();
        compare_field("neuron_out", want.neuron_out, 32'(got.neuron_out), 32'(want.neuron_out));
        compare_field("spiked", want.neuron_out, 32'(got.spiked), 32'(want.spiked));
        compare_field("was_refractory", want.neuron_out, 32'(got.was_refractory),
                      32'(want.was_refractory));
        compare_field("new_potential", want.neuron_out, got.new_potential, want.new_potential);
        compare_field("saturated", want.neuron_out, 32'(got.saturated), 32'(want.saturated));
        compare_field("mode_fault", want.neuron_out, 32'(got.mode_fault), 32'(want.mode_fault));
    endtask

    task automatic push_item(input item_t it, input bit known, input result_t want);
        result_t predicted;
        item <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        predicted = lif_update(it);
        expected_results.push_back(known ? want : predicted);
        items_sent++;
        spikes_seen += predicted.spiked;
        frozen_seen += predicted.was_refractory;
        clipped_seen += predicted.saturated;
        faults_seen += predicted.mode_fault;
    endtask

    task automatic idle_items(input int gap);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [CFG_DATA_W-1:0] val);
        item_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        cfg_index <= sel;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (sel)
            CFG_REFRACTORY: live_cfg.refractory_steps = val[REFR_W-1:0];
            CFG_DECAY:      live_cfg.decay_factor = val[DECAY_W-1:0];
            CFG_THRESHOLD:  live_cfg.threshold = val;
            CFG_LEVEL:      live_cfg.reset_level = val;
            CFG_MODE:       live_cfg.reset_mode = val[0];
            default:        ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // result side: random stalls, one long hold-off, quiet stretches
    initial
    begin
        int stall;
        @(posedge clk);
        forever
        begin
            if (results_seen == HOLD_AT && !held_off)
            begin
                held_off = 1'b1;
                stall = HOLD_OFF_CYCLES;
            end
            else
                stall = ((results_seen / 50) % 3 == 2) ? 0 : pick_gap();
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            @(posedge clk);
            while (!result_valid)
                @(posedge clk);
            check_result(result);
            results_seen++;
        end
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
            @(posedge clk);
        $display("timeout after %0d cycles with %0d results pending", cycles,
                 expected_results.size());
        $display("status: fail");
        $finish;
    end

    initial
    begin
        item_t                   stim;
        cfg_t                    setting;
        logic [IDX_W-1:0]        pool [POOL];
        logic [STEP_W-1:0]       sim_step;
        logic signed [POT_W-1:0] drive;
        bit                      steady;
        int                      roll;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_WRITE)
                write_reg(directed_rows[i].sel, directed_rows[i].val);
            else
            begin
                push_item(directed_rows[i].stim, directed_rows[i].kind == ROW_KNOWN,
                          directed_rows[i].want);
                idle_items(pick_gap());
            end
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            setting = (ph < FIXED_PHASES) ? fixed_settings[ph] : random_setting();
            write_reg(CFG_REFRACTORY, CFG_DATA_W'(setting.refractory_steps));
            write_reg(CFG_DECAY, CFG_DATA_W'(setting.decay_factor));
            write_reg(CFG_THRESHOLD, setting.threshold);
            write_reg(CFG_LEVEL, setting.reset_level);
            write_reg(CFG_MODE, CFG_DATA_W'(setting.reset_mode));
            foreach (pool[j])
                pool[j] = $urandom_range(0, NEURONS - 1);
            sim_step = (ph == 0) ? 32'hFFFF_FFF0 : $urandom;
            steady = (ph % 3 == 1);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                roll = $urandom_range(0, 19);
                if (roll == 0)
                    sim_step = $urandom;
                else if (roll == 1)
                    sim_step += $urandom_range(60000, 70000);
                else
                    sim_step += $urandom_range(0, 2);
                stim.neuron_index = ($urandom_range(0, 4) == 0) ?
                    IDX_W'($urandom_range(0, NEURONS - 1)) : pool[$urandom_range(0, POOL - 1)];
                stim.step_number = sim_step;
                case ($urandom_range(0, 9))
                    0: drive = $urandom;
                    1: drive = $urandom_range(0, 1) ? POT_MAX : POT_MIN;
                    2: drive = '0;
                    default:
                    begin
                        drive = $urandom >> $urandom_range(10, 18);
                        if ($urandom_range(0, 9) < 3)
                            drive = -drive;
                    end
                endcase
                stim.synaptic_input = drive;
                push_item(stim, 1'b0, '0);
                idle_items(steady ? 0 : pick_gap());
            end
        end

        item_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d items in, %0d results compared across %0d register settings",
                 items_sent, results_seen, PHASES + 1);
        $display("%0d spikes, %0d frozen, %0d clipped, %0d mode faults, %0d mismatches",
                 spikes_seen, frozen_seen, clipped_seen, faults_seen, mismatches);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
